/* rtl/crfs_pkg.sv */
package crfs_pkg;

    localparam int RECORD_MAX_DEF = 256;
    localparam int MAX_FIELDS_DEF = 16;
    localparam int OBUF_DEPTH     = 4;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_OPEN  = 2'd1,
        KIND_QUOTE = 2'd2,
        KIND_END   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  out_char;
        logic [3:0]  field_number;
        logic [4:0]  field_count;
        logic        too_many_fields;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0] n;
        t_result    e0;
        t_result    e1;
    } t_push;

endpackage

/* rtl/csv_record_field_splitter_unit.sv */
// output: each result is registered into the result queue as its input beat is accepted
// throughput: one input beat per cycle while the 4-entry result queue, which sets how far
// input runs ahead, has room for two; a byte that fills a record can give two results
// reset: synchronous, active low; clears the record state and empties the result queue
module csv_record_field_splitter_unit
    import crfs_pkg::*;
#(
    parameter int RECORD_MAX = RECORD_MAX_DEF,
    parameter int MAX_FIELDS = MAX_FIELDS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_char,
    input  logic       i_end_of_input,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_char,
    output logic [3:0] o_field_number,
    output logic [4:0] o_field_count,
    output logic       o_too_many_fields,
    output logic       o_last
);

    logic    accept;
    t_push   push;
    t_result res;

    assign accept = i_in_valid && o_in_ready;

    crfs_core #(
        .RECORD_MAX (RECORD_MAX),
        .MAX_FIELDS (MAX_FIELDS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_in_char      (i_in_char),
        .i_end_of_input (i_end_of_input),
        .o_push         (push)
    );

    crfs_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (res)
    );

    assign o_kind            = res.kind;
    assign o_out_char        = res.out_char;
    assign o_field_number    = res.field_number;
    assign o_field_count     = res.field_count;
    assign o_too_many_fields = res.too_many_fields;
    assign o_last            = res.last;

`ifndef NO_ASSERTIONS
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_END |-> o_last)
        else $error("record end beat without last");

    a_open_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_OPEN || o_kind == KIND_QUOTE) |-> o_field_count != 5'd0)
        else $error("field opened with zero field count");

    a_stall_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty result queue");

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.n != 2'd0 |-> o_in_ready)
        else $error("results pushed without queue room");
`endif

endmodule

/* rtl/crfs_core.sv */
module crfs_core
    import crfs_pkg::*;
#(
    parameter int RECORD_MAX = RECORD_MAX_DEF,
    parameter int MAX_FIELDS = MAX_FIELDS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_in_char,
    input  logic       i_end_of_input,
    output t_push      o_push
);

    localparam int KW = $clog2(RECORD_MAX);
    localparam int OW = $clog2(MAX_FIELDS + 1);
    localparam int EW = (OW > 5) ? OW : 5;

    typedef enum logic [3:0] {
        PH_WAIT   = 4'b0001,
        PH_QUOTED = 4'b0010,
        PH_CLOSED = 4'b0100,
        PH_PLAIN  = 4'b1000
    } t_phase;

    logic [KW-1:0] r_kept,    n_kept;
    logic          r_armed,   n_armed;
    logic          r_comment, n_comment;
    t_phase        r_phase,   n_phase;
    logic [OW-1:0] r_open,    n_open;
    logic          r_ovf,     n_ovf;

    logic          fld_v;
    logic          end_v;
    logic          clr;
    logic          open_try;
    t_kind         fld_kind;
    logic [7:0]    fld_char;
    logic [KW:0]   kept_next;
    logic [EW-1:0] open_ext;
    logic [EW-1:0] open_dec;
    logic [4:0]    fc;
    logic [3:0]    fn;
    t_result       fld_res;
    t_result       end_res;

    always_comb begin
        n_kept    = r_kept;
        n_armed   = r_armed;
        n_comment = r_comment;
        n_phase   = r_phase;
        n_open    = r_open;
        n_ovf     = r_ovf;
        fld_v     = 1'b0;
        end_v     = 1'b0;
        clr       = 1'b0;
        open_try  = 1'b0;
        fld_kind  = KIND_BYTE;
        fld_char  = 8'd0;
        kept_next = {1'b0, r_kept} + {{KW{1'b0}}, 1'b1};

        priority if (i_end_of_input) begin
            end_v = (r_kept != '0);
            clr   = 1'b1;
        end else if (i_in_char == CH_CR || i_in_char == CH_LF || i_in_char == CH_TAB) begin
            n_comment = 1'b0;
        end else if (r_comment) begin
            n_comment = 1'b1;
        end else if (i_in_char == CH_SLASH) begin
            if (r_armed) begin
                n_armed   = 1'b0;
                n_comment = 1'b1;
            end else begin
                n_armed = 1'b1;
            end
        end else if (i_in_char == CH_SEMI) begin
            end_v = (r_kept != '0);
            clr   = 1'b1;
        end else begin
            unique case (r_phase)
                PH_WAIT: begin
                    if (i_in_char == CH_QUOTE) begin
                        n_phase  = PH_QUOTED;
                        open_try = 1'b1;
                        fld_kind = KIND_QUOTE;
                    end else if (i_in_char != CH_SPACE) begin
                        n_phase  = PH_PLAIN;
                        open_try = 1'b1;
                        fld_kind = KIND_OPEN;
                        fld_char = i_in_char;
                    end
                end
                PH_QUOTED: begin
                    if (i_in_char == CH_QUOTE) begin
                        n_phase = PH_CLOSED;
                    end else begin
                        fld_v    = !r_ovf;
                        fld_char = i_in_char;
                    end
                end
                PH_CLOSED: begin
                    if (i_in_char == CH_COMMA) begin
                        n_phase = PH_WAIT;
                    end
                end
                PH_PLAIN: begin
                    if (i_in_char == CH_COMMA) begin
                        n_phase = PH_WAIT;
                    end else begin
                        fld_v    = !r_ovf;
                        fld_char = i_in_char;
                    end
                end
                default: begin
                    n_phase = PH_WAIT;
                end
            endcase
            if (open_try) begin
                if (r_ovf || r_open >= OW'(MAX_FIELDS)) begin
                    n_ovf = 1'b1;
                end else begin
                    n_open = r_open + OW'(1);
                    fld_v  = 1'b1;
                end
            end
            if (kept_next == (KW+1)'(RECORD_MAX)) begin
                end_v = 1'b1;
                clr   = 1'b1;
            end else begin
                n_kept = kept_next[KW-1:0];
            end
        end

        // result fields use the field state before the record is cleared
        open_ext = EW'(n_open);
        open_dec = open_ext - EW'(1);
        fc       = (open_ext > EW'(31)) ? 5'd31 : open_ext[4:0];
        fn       = (open_ext == '0) ? 4'd0 : open_dec[3:0];

        fld_res.kind            = fld_kind;
        fld_res.out_char        = fld_char;
        fld_res.field_number    = fn;
        fld_res.field_count     = fc;
        fld_res.too_many_fields = n_ovf;
        fld_res.last            = !end_v;

        end_res.kind            = KIND_END;
        end_res.out_char        = 8'd0;
        end_res.field_number    = fn;
        end_res.field_count     = fc;
        end_res.too_many_fields = n_ovf;
        end_res.last            = 1'b1;

        o_push.n  = i_accept ? ({1'b0, fld_v} + {1'b0, end_v}) : 2'd0;
        o_push.e0 = fld_v ? fld_res : end_res;
        o_push.e1 = end_res;

        if (clr) begin
            n_kept    = '0;
            n_armed   = 1'b0;
            n_comment = 1'b0;
            n_phase   = PH_WAIT;
            n_open    = '0;
            n_ovf     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept    <= '0;
            r_armed   <= 1'b0;
            r_comment <= 1'b0;
            r_phase   <= PH_WAIT;
            r_open    <= '0;
            r_ovf     <= 1'b0;
        end else if (i_accept) begin
            r_kept    <= n_kept;
            r_armed   <= n_armed;
            r_comment <= n_comment;
            r_phase   <= n_phase;
            r_open    <= n_open;
            r_ovf     <= n_ovf;
        end
    end

endmodule

/* rtl/crfs_obuf.sv */
module crfs_obuf
    import crfs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    localparam int PW = $clog2(OBUF_DEPTH);
    localparam int CW = $clog2(OBUF_DEPTH + 1);

    t_result       r_mem [OBUF_DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_count, n_count;
    logic          pop;
    logic [PW-1:0] wp1;

    assign pop     = o_valid && i_ready;
    assign wp1     = r_wp + PW'(1);
    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= CW'(OBUF_DEPTH - 2));
    assign o_res   = r_mem[r_rp];

    always_comb begin
        n_wp    = r_wp + PW'(i_push.n);
        n_rp    = pop ? (r_rp + PW'(1)) : r_rp;
        n_count = r_count + CW'(i_push.n) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wp] <= i_push.e0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[wp1] <= i_push.e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

/* test/tb_csv_record_field_splitter_unit.sv */
`timescale 1ns / 100ps

module tb_csv_record_field_splitter_unit;
    import crfs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_QUOTED,
        PH_AFTER_QUOTE,
        PH_BARE
    } t_split_phase;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_in_char = 8'd0;
    logic       i_end_of_input = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [1:0] o_kind;
    logic [7:0] o_out_char;
    logic [3:0] o_field_number;
    logic [4:0] o_field_count;
    logic       o_too_many_fields;
    logic       o_last;

    csv_record_field_splitter_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_in_char        (i_in_char),
        .i_end_of_input   (i_end_of_input),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_out_char       (o_out_char),
        .o_field_number   (o_field_number),
        .o_field_count    (o_field_count),
        .o_too_many_fields(o_too_many_fields),
        .o_last           (o_last)
    );

    // splitter state mirrored for prediction
    int           kept_cnt = 0;
    bit           slash_armed = 1'b0;
    bit           in_comment = 1'b0;
    t_split_phase phase = PH_IDLE;
    int           open_cnt = 0;
    bit           overflow = 1'b0;

    t_result pending_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors = 0;
    int beats_sent = 0;
    int results_checked = 0;
    int records_closed = 0;
    int fields_dropped = 0;
    int full_records = 0;
    int stall_cycles = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic void push_expect(t_kind k, logic [7:0] c);
        t_result r;
        r.kind = k;
        r.out_char = c;
        r.field_number = (open_cnt == 0) ? 4'd0 : 4'((open_cnt - 1) & 15);
        r.field_count = (open_cnt > 31) ? 5'd31 : 5'(open_cnt);
        r.too_many_fields = overflow;
        r.last = 1'b0;
        pending_results.push_back(r);
    endfunction

    function automatic bit take_field();
        if (overflow || open_cnt >= MAX_FIELDS_DEF) begin
            overflow = 1'b1;
            fields_dropped++;
            return 1'b0;
        end
        open_cnt++;
        return 1'b1;
    endfunction

    function automatic void close_record();
        if (kept_cnt > 0) begin
            push_expect(KIND_END, 8'd0);
        end
        kept_cnt = 0;
        slash_armed = 1'b0;
        in_comment = 1'b0;
        phase = PH_IDLE;
        open_cnt = 0;
        overflow = 1'b0;
    endfunction

    function automatic void split_kept_byte(logic [7:0] c);
        case (phase)
            PH_IDLE: begin
                if (c == CH_QUOTE) begin
                    phase = PH_QUOTED;
                    if (take_field()) push_expect(KIND_QUOTE, 8'd0);
                end else if (c != CH_SPACE) begin
                    phase = PH_BARE;
                    if (take_field()) push_expect(KIND_OPEN, c);
                end
            end
            PH_QUOTED: begin
                if (c == CH_QUOTE) phase = PH_AFTER_QUOTE;
                else if (!overflow) push_expect(KIND_BYTE, c);
            end
            PH_AFTER_QUOTE: begin
                if (c == CH_COMMA) phase = PH_IDLE;
            end
            default: begin
                if (c == CH_COMMA) phase = PH_IDLE;
                else if (!overflow) push_expect(KIND_BYTE, c);
            end
        endcase
    endfunction

    function automatic void track_splitter_step(logic [7:0] c, logic eoi);
        int      prior;
        t_result tail;
        prior = pending_results.size();
        if (eoi) begin
            close_record();
        end else if (c == CH_CR || c == CH_LF || c == CH_TAB) begin
            in_comment = 1'b0;
        end else if (!in_comment) begin
            if (c == CH_SLASH) begin
                if (slash_armed) begin
                    slash_armed = 1'b0;
                    in_comment = 1'b1;
                end else begin
                    slash_armed = 1'b1;
                end
            end else if (c == CH_SEMI) begin
                close_record();
            end else begin
                split_kept_byte(c);
                kept_cnt++;
                if (kept_cnt >= RECORD_MAX_DEF) begin
                    full_records++;
                    close_record();
                end
            end
        end
        if (pending_results.size() > prior) begin
            tail = pending_results.pop_back();
            tail.last = 1'b1;
            pending_results.push_back(tail);
        end
    endfunction

    task automatic send_beat(input logic [7:0] c, input logic eoi);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_char <= c;
        i_end_of_input <= eoi;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        track_splitter_step(c, eoi);
        beats_sent++;
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(255));
        while (c inside {CH_CR, CH_LF, CH_TAB, CH_SLASH, CH_SEMI, CH_QUOTE, CH_COMMA});
        return c;
    endfunction

    function automatic logic [7:0] quoted_byte();
        return ($urandom_range(7) == 0) ? CH_COMMA : plain_byte();
    endfunction

    task automatic send_comment();
        logic [7:0] c;
        case ($urandom_range(2))
            0: begin
                send_beat(CH_SLASH, 1'b0);
                send_beat(CH_SLASH, 1'b0);
                repeat ($urandom_range(6)) begin
                    do c = 8'($urandom_range(255));
                    while (c inside {CH_CR, CH_LF, CH_TAB});
                    send_beat(c, 1'b0);
                end
                case ($urandom_range(2))
                    0: send_beat(CH_CR, 1'b0);
                    1: send_beat(CH_LF, 1'b0);
                    default: send_beat(CH_TAB, 1'b0);
                endcase
            end
            1: send_beat(CH_SLASH, 1'b0);
            default: send_beat(($urandom_range(1) == 0) ? CH_LF : CH_CR, 1'b0);
        endcase
    endtask

    task automatic send_record(input int n_fields, input int max_len);
        for (int f = 0; f < n_fields; f++) begin
            if (f > 0) send_beat(CH_COMMA, 1'b0);
            repeat ($urandom_range(2)) send_beat(CH_SPACE, 1'b0);
            if ($urandom_range(99) < 30) begin
                send_beat(CH_QUOTE, 1'b0);
                repeat ($urandom_range(max_len)) send_beat(quoted_byte(), 1'b0);
                if ($urandom_range(9) != 0) begin
                    send_beat(CH_QUOTE, 1'b0);
                    repeat ($urandom_range(2)) send_beat(plain_byte(), 1'b0);
                end
            end else begin
                send_beat(plain_byte(), 1'b0);
                repeat ($urandom_range(max_len)) send_beat(plain_byte(), 1'b0);
            end
            if ($urandom_range(19) == 0) send_comment();
        end
        if ($urandom_range(4) == 0) send_beat(8'($urandom_range(255)), 1'b1);
        else send_beat(CH_SEMI, 1'b0);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        string s;
        s = " \"a\"\"x,b,,/q//;\n ;/;";
        for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
        send_beat(CH_CR, 1'b0);
        send_beat(CH_TAB, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hA5, 1'b1);
        send_beat(8'h5A, 1'b1);
        send_beat(CH_QUOTE, 1'b0);
        send_beat(8'h00, 1'b1);
    endtask

    task automatic test_field_overflow();
        repeat (3) send_record($urandom_range(17, 20), 2);
    endtask

    task automatic test_full_record(input bit quoted);
        // end of input closes the record even inside a comment
        send_beat(8'h00, 1'b1);
        if (quoted) send_beat(CH_QUOTE, 1'b0);
        do begin
            send_beat(($urandom_range(39) == 0) ? CH_COMMA : plain_byte(), 1'b0);
        end while (kept_cnt != 0);
    endtask

    task automatic test_drain_pause();
        send_record(2, 4);
        send_beat(plain_byte(), 1'b0);
        drain_results();
        send_beat(CH_SEMI, 1'b0);
    endtask

    task automatic test_random_mix(input int n_beats);
        int start;
        start = beats_sent;
        while (beats_sent - start < n_beats) begin
            case ($urandom_range(9))
                7: send_record($urandom_range(17, 19), 2);
                8: begin
                    repeat ($urandom_range(5, 20))
                        send_beat(8'($urandom_range(255)), $urandom_range(29) == 0);
                end
                9: send_record($urandom_range(1, 3), 20);
                default: send_record($urandom_range(5), 6);
            endcase
        end
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            errors++;
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $error("result beat with nothing expected: kind %0d char %0d",
                       o_kind, o_out_char);
            end else begin
                want = pending_results.pop_front();
                check_field("kind", want.kind, o_kind);
                check_field("out_char", want.out_char, o_out_char);
                check_field("field_number", want.field_number, o_field_number);
                check_field("field_count", want.field_count, o_field_count);
                check_field("too_many_fields", want.too_many_fields, o_too_many_fields);
                check_field("last", want.last, o_last);
                results_checked++;
                if (want.kind == KIND_END) records_closed++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     stall_cycles, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        send_idle_pct = 20;
        recv_idle_pct = 85;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_field_overflow();
        test_full_record(1'b1);
        test_drain_pause();
        test_random_mix(150);

        send_idle_pct = 85;
        recv_idle_pct = 20;
        test_random_mix(250);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_full_record(1'b0);
        test_random_mix(150);

        drain_results();
        repeat (10) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            errors++;
            $error("%0d expected results never arrived", pending_results.size());
        end
        $display("run covered %0d input beats and %0d checked results over %0d records",
                 beats_sent, results_checked, records_closed);
        $display("%0d fields dropped past the field limit, %0d records cut at %0d bytes",
                 fields_dropped, full_records, RECORD_MAX_DEF);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* csv_record_field_splitter_unit.f */
rtl/crfs_pkg.sv
rtl/crfs_core.sv
rtl/crfs_obuf.sv
rtl/csv_record_field_splitter_unit.sv
test/tb_csv_record_field_splitter_unit.sv
